/* rtl/core/irt_pkg.sv */
// ----------------------------------------------------------------------------
// irt_pkg
// Shared sizes, codes and types for the inode reference table.
// ----------------------------------------------------------------------------
package irt_pkg;

    // table geometry
    localparam int SLOTS      = 64;
    localparam int INODE_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(SLOTS);

    // item field widths
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int INO_F_W    = 16;
    localparam int CNT_F_W    = 16;
    localparam int STATUS_W   = 3;

    // width used to compare a requested slot against a cell index
    localparam int CMP_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LAST      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd7;

    // query held steady by the controller while a token walks the row
    typedef struct packed {
        logic                  is_get;
        logic [INODE_BITS-1:0] key;
        logic [SLOT_W-1:0]     slot;
    } t_qry;

    // search token handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [COUNT_BITS-1:0] cnt;
        logic [INODE_BITS-1:0] ino;
        logic                  free;
        logic [IDX_W-1:0]      fidx;
    } t_tok;

    // update broadcast to every cell
    typedef struct packed {
        logic                  en;
        logic                  clr;
        logic [IDX_W-1:0]      idx;
        logic [INODE_BITS-1:0] ino;
        logic [COUNT_BITS-1:0] cnt;
    } t_wr;

endpackage

/* rtl/core/inode_ref_table.sv */
// ----------------------------------------------------------------------------
// inode_ref_table
// Reference-counted table of open inodes built as a row of slot cells.
// ----------------------------------------------------------------------------
// A get, put, clear or unused item is taken whenever no other item is in
// flight; a get or put sends a search token down the row of SLOTS cells,
// one cell per cycle, and reaches the finishing state once the token leaves
// the last cell. A clear or an unused kind skips the row and goes straight
// to the finishing state. Results wait in an output register, so the next
// item is taken while a result is still pending; the row's update is
// applied when that result is registered. All slots are free after reset,
// with no clearing pass.
module inode_ref_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] inode_number, [21:16] slot, [23:22] zero
    input  logic [23:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] slot_out, [21:6] inode_out, [37:22] count_out,
    // [38] fetch_request, [39] write_back
    output logic [39:0] o_m_tdata,
    // [2:0] status
    output logic [2:0]  o_m_tuser
);
    import irt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [KIND_W-1:0]     r_kind;
    logic [INODE_BITS-1:0] r_key;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_inject;
    t_tok                  r_res;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [SLOT_W-1:0]     r_slot_out, n_slot_out;
    logic [INO_F_W-1:0]    r_ino_out, n_ino_out;
    logic [CNT_F_W-1:0]    r_cnt_out, n_cnt_out;
    logic                  r_fetch, n_fetch;
    logic                  r_wb, n_wb;

    logic                  s_acc;
    logic                  commit;
    logic [KIND_W-1:0]     in_kind;
    logic                  in_scan;
    logic [COUNT_BITS-1:0] cnt_dec;

    t_qry                  qry;
    t_wr                   wr;
    t_tok                  tok_head;
    t_tok                  tok [SLOTS+1];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_kind    = i_s_tuser[KIND_W-1:0];
    assign in_scan    = (in_kind == KIND_GET) || (in_kind == KIND_PUT);
    assign commit     = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign cnt_dec    = r_res.cnt - 1'b1;

    assign qry.is_get = (r_kind == KIND_GET);
    assign qry.key    = r_key;
    assign qry.slot   = r_slot;

    always_comb begin
        tok_head       = '0;
        tok_head.valid = r_inject;
    end

    assign tok[0] = tok_head;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        irt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_qry   (qry),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) n_state = in_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (tok[SLOTS].valid) n_state = S_DONE;
            end
            S_DONE: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result and table update for the item being finished
    always_comb begin
        wr         = '0;
        n_status   = ST_IGNORED;
        n_slot_out = '0;
        n_ino_out  = '0;
        n_cnt_out  = '0;
        n_fetch    = 1'b0;
        n_wb       = 1'b0;
        case (r_kind)
            KIND_GET: begin
                if (r_res.found) begin
                    n_slot_out = SLOT_W'(r_res.idx);
                    n_ino_out  = INO_F_W'(r_key);
                    if (r_res.cnt == COUNT_MAX) begin
                        n_status  = ST_SATURATED;
                        n_cnt_out = CNT_F_W'(r_res.cnt);
                    end else begin
                        n_status  = ST_HIT;
                        n_cnt_out = CNT_F_W'(COUNT_BITS'(r_res.cnt + 1'b1));
                        wr.en     = commit;
                        wr.idx    = r_res.idx;
                        wr.ino    = r_key;
                        wr.cnt    = COUNT_BITS'(r_res.cnt + 1'b1);
                    end
                end else if (r_res.free) begin
                    n_status   = ST_LOADED;
                    n_slot_out = SLOT_W'(r_res.fidx);
                    n_ino_out  = INO_F_W'(r_key);
                    n_cnt_out  = CNT_F_W'(1);
                    n_fetch    = 1'b1;
                    wr.en      = commit;
                    wr.idx     = r_res.fidx;
                    wr.ino     = r_key;
                    wr.cnt     = COUNT_BITS'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            KIND_PUT: begin
                if (r_res.found) begin
                    n_slot_out = SLOT_W'(r_res.idx);
                    n_ino_out  = INO_F_W'(r_res.ino);
                    n_cnt_out  = CNT_F_W'(cnt_dec);
                    if (cnt_dec == '0) begin
                        n_status = ST_LAST;
                        n_wb     = 1'b1;
                    end else begin
                        n_status = ST_RELEASED;
                    end
                    wr.en  = commit;
                    wr.idx = r_res.idx;
                    wr.ino = r_res.ino;
                    wr.cnt = cnt_dec;
                end
            end
            KIND_CLEAR: begin
                n_status = ST_CLEARED;
                wr.clr   = commit;
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= s_acc && in_scan;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind <= in_kind;
            r_key  <= INODE_BITS'(i_s_tdata[INO_F_W-1:0]);
            r_slot <= i_s_tdata[INO_F_W +: SLOT_W];
        end
        if (tok[SLOTS].valid) begin
            r_res <= tok[SLOTS];
        end
        if (commit) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_ino_out  <= n_ino_out;
            r_cnt_out  <= n_cnt_out;
            r_fetch    <= n_fetch;
            r_wb       <= n_wb;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {r_wb, r_fetch, r_cnt_out, r_ino_out, r_slot_out};

`ifndef SYNTHESIS
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[SLOTS].valid |-> (r_state == S_SCAN))
        else $error("search token left the row outside a scan");

    a_wr_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en || wr.clr) |-> (r_state == S_DONE))
        else $error("table update outside the finishing state");

    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && in_scan) |=> (r_inject && (r_state == S_SCAN)))
        else $error("get or put item did not start a scan");

    a_fetch_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_fetch || r_wb)) |->
            ((r_fetch && r_status == ST_LOADED) || (r_wb && r_status == ST_LAST)))
        else $error("request flag with wrong status");
`endif

endmodule

/* rtl/core/irt_cell.sv */
// ----------------------------------------------------------------------------
// irt_cell
// One table slot: holds an inode number and its count, and passes the
// search token on to the next slot, marking the first match and first free.
// ----------------------------------------------------------------------------
module irt_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [irt_pkg::IDX_W-1:0] i_idx,
    input  irt_pkg::t_qry            i_qry,
    input  irt_pkg::t_wr             i_wr,
    input  irt_pkg::t_tok            i_tok,
    output irt_pkg::t_tok            o_tok
);
    import irt_pkg::*;

    logic [INODE_BITS-1:0] r_inode, n_inode;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_tok                  r_tok, n_tok;
    logic                  in_use;
    logic                  key_eq;
    logic                  hit;
    logic                  free_here;

    assign in_use    = (r_count != '0);
    assign key_eq    = i_qry.is_get ? (r_inode == i_qry.key)
                                    : (CMP_W'(i_qry.slot) == CMP_W'(i_idx));
    assign hit       = i_tok.valid && !i_tok.found && in_use && key_eq;
    assign free_here = i_tok.valid && !i_tok.free && !in_use;

    always_comb begin
        n_tok = i_tok;
        if (hit) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_idx;
            n_tok.cnt   = r_count;
            n_tok.ino   = r_inode;
        end
        if (free_here) begin
            n_tok.free = 1'b1;
            n_tok.fidx = i_idx;
        end
    end

    always_comb begin
        n_inode = r_inode;
        n_count = r_count;
        if (i_wr.clr) begin
            n_count = '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            n_inode = i_wr.ino;
            n_count = i_wr.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_inode <= '0;
            r_count <= '0;
        end else begin
            r_tok   <= n_tok;
            r_inode <= n_inode;
            r_count <= n_count;
        end
    end

    assign o_tok = r_tok;

endmodule
